/* hw/rtl/sbf_pkg.sv */
// Shared types and constants for the stereo biquad filter.
// Depends on nothing; every other file of the block imports it.
package sbf_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_WIDTH     = 20;
    localparam int COEF_FRAC_BITS = 16;
    localparam int CHANNELS       = 2;
    localparam int NUM_COEFS      = 5;
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_X0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_X1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_X2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Y1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Y2 = 3'd4;

    localparam logic signed [COEF_WIDTH-1:0] COEF_X0_RESET = 20'sd65536;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [COEF_WIDTH-1:0]   coef_t;

    typedef struct packed {
        coef_t x0;
        coef_t x1;
        coef_t x2;
        coef_t y1;
        coef_t y2;
    } coef_set_t;

    typedef struct packed {
        sample_t sample_in;
        logic    start_of_stream;
    } sbf_in_t;

    typedef struct packed {
        sample_t sample_out;
        logic    channel_out;
        logic    clipped;
    } sbf_out_t;

endpackage

/* hw/rtl/sbf_coef_regs.sv */
// Coefficient register file of the stereo biquad filter, written over the config channel.
// Depends on sbf_pkg.
module sbf_coef_regs
    import sbf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  coef_t                cfg_data,
    output coef_set_t            coefs
);

    coef_set_t coefs_reg;
    coef_set_t coefs_next;

    always_comb
    begin
        coefs_next = coefs_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_COEF_X0: coefs_next.x0 = cfg_data;
                REG_COEF_X1: coefs_next.x1 = cfg_data;
                REG_COEF_X2: coefs_next.x2 = cfg_data;
                REG_COEF_Y1: coefs_next.y1 = cfg_data;
                REG_COEF_Y2: coefs_next.y2 = cfg_data;
                default:     coefs_next = coefs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg.x0 <= COEF_X0_RESET;
            coefs_reg.x1 <= '0;
            coefs_reg.x2 <= '0;
            coefs_reg.y1 <= '0;
            coefs_reg.y2 <= '0;
        end
        else
        begin
            coefs_reg <= coefs_next;
        end
    end

    assign coefs = coefs_reg;

endmodule

/* hw/rtl/sbf_datapath.sv */
// Multiply-accumulate, rounding and saturation for one biquad sample.
// Depends on sbf_pkg; purely combinational, placed between two register stages.
module sbf_datapath
    import sbf_pkg::*;
#(
    parameter int COEF_FRAC_BITS_P = COEF_FRAC_BITS
)
(
    input  coef_set_t coefs,
    input  sample_t   x,
    input  sample_t   x1,
    input  sample_t   x2,
    input  sample_t   y1,
    input  sample_t   y2,
    input  logic      channel,
    output sbf_out_t  result
);

    localparam int PW = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int AW = PW + 3;
    localparam int RW = AW + 1;
    localparam logic signed [RW-1:0] HALF = RW'(64'd1 << (COEF_FRAC_BITS_P - 1));
    localparam logic signed [RW-1:0] SMAX = RW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] SMIN = -SMAX - RW'(1);

    logic signed [PW-1:0] p0;
    logic signed [PW-1:0] p1;
    logic signed [PW-1:0] p2;
    logic signed [PW-1:0] p3;
    logic signed [PW-1:0] p4;
    logic signed [AW-1:0] acc;
    logic signed [RW-1:0] rnd;
    logic signed [RW-1:0] shifted;

    assign p0 = coefs.x0 * x;
    assign p1 = coefs.x1 * x1;
    assign p2 = coefs.x2 * x2;
    assign p3 = coefs.y1 * y1;
    assign p4 = coefs.y2 * y2;

    assign acc = AW'(p0) + AW'(p1) + AW'(p2) - AW'(p3) - AW'(p4);
    assign rnd = RW'(acc) + HALF;
    assign shifted = rnd >>> COEF_FRAC_BITS_P;

    always_comb
    begin
        result.channel_out = channel;
        if (shifted > SMAX)
        begin
            result.sample_out = SMAX[SAMPLE_WIDTH-1:0];
            result.clipped    = 1'b1;
        end
        else if (shifted < SMIN)
        begin
            result.sample_out = SMIN[SAMPLE_WIDTH-1:0];
            result.clipped    = 1'b1;
        end
        else
        begin
            result.sample_out = shifted[SAMPLE_WIDTH-1:0];
            result.clipped    = 1'b0;
        end
    end

endmodule

/* hw/rtl/stereo_biquad_filter.sv */
// Top level of the stereo biquad filter: input stage, channel histories, result stage.
// Depends on sbf_pkg, sbf_coef_regs and sbf_datapath.
//
//   channel   signals                                 request
//   sample    sample_valid / sample_stall / sample_data  sbf_in_t (sample, stream start)
//   result    result_valid / result_stall / result_data  sbf_out_t (sample, channel, clip)
//   config    cfg_valid / cfg_ready / cfg_index / cfg_data  coefficient write
//
// A sample is taken into the input stage and its result is then registered in the result
// register; one sample is accepted every cycle while the result channel does not stall.
// The rate is set by the combinational multiply-accumulate between the two stages.
// Reset clears coefficients to unity gain, all histories to zero and the channel to left.
// A stalled result holds the input stage, which then stalls the sample channel.
// Config writes are always ready.
module stereo_biquad_filter
    import sbf_pkg::*;
#(
    parameter int COEF_FRAC_BITS_P = COEF_FRAC_BITS,
    parameter int CHANNELS_P       = CHANNELS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  sbf_in_t              sample_data,
    output logic                 result_valid,
    input  logic                 result_stall,
    output sbf_out_t             result_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  coef_t                cfg_data
);

    localparam int CH_W = (CHANNELS_P > 1) ? $clog2(CHANNELS_P) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS_P - 1);

    coef_set_t coefs;

    logic      s1_valid_reg;
    logic      s1_valid_next;
    sbf_in_t   s1_data_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    sbf_out_t  out_data_reg;
    sbf_out_t  result;

    logic [CH_W-1:0] next_channel_reg;
    logic [CH_W-1:0] channel;
    sample_t         x1_reg [CHANNELS_P];
    sample_t         x2_reg [CHANNELS_P];
    sample_t         y1_reg [CHANNELS_P];
    sample_t         y2_reg [CHANNELS_P];
    sample_t         h_x1;
    sample_t         h_x2;
    sample_t         h_y1;
    sample_t         h_y2;

    logic s1_advance;
    logic accept;
    logic start;

    assign cfg_ready = 1'b1;

    sbf_coef_regs u_coef_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs)
    );

    assign s1_advance   = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign sample_stall = s1_valid_reg && !s1_advance;
    assign accept       = sample_valid && !sample_stall;
    assign start        = s1_data_reg.start_of_stream;

    assign channel = start ? '0 : next_channel_reg;

    always_comb
    begin
        if (start)
        begin
            h_x1 = '0;
            h_x2 = '0;
            h_y1 = '0;
            h_y2 = '0;
        end
        else
        begin
            h_x1 = x1_reg[channel];
            h_x2 = x2_reg[channel];
            h_y1 = y1_reg[channel];
            h_y2 = y2_reg[channel];
        end
    end

    sbf_datapath #(
        .COEF_FRAC_BITS_P (COEF_FRAC_BITS_P)
    ) u_datapath (
        .coefs   (coefs),
        .x       (s1_data_reg.sample_in),
        .x1      (h_x1),
        .x2      (h_x2),
        .y1      (h_y1),
        .y2      (h_y2),
        .channel (channel[0]),
        .result  (result)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg <= sample_data;
        end
        if (s1_advance)
        begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_channel_reg <= '0;
            for (int i = 0; i < CHANNELS_P; i++)
            begin
                x1_reg[i] <= '0;
                x2_reg[i] <= '0;
                y1_reg[i] <= '0;
                y2_reg[i] <= '0;
            end
        end
        else if (s1_advance)
        begin
            next_channel_reg <= (channel == LAST_CH) ? '0 : channel + 1'b1;
            for (int i = 0; i < CHANNELS_P; i++)
            begin
                if (CH_W'(i) == channel)
                begin
                    x1_reg[i] <= s1_data_reg.sample_in;
                    x2_reg[i] <= h_x1;
                    y1_reg[i] <= result.sample_out;
                    y2_reg[i] <= h_y1;
                end
                else if (start)
                begin
                    x1_reg[i] <= '0;
                    x2_reg[i] <= '0;
                    y1_reg[i] <= '0;
                    y2_reg[i] <= '0;
                end
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

endmodule

/* tb/tb_stereo_biquad_filter.sv */
// Self-checking testbench for the stereo biquad filter: a directed table, then random phases
// with their own coefficient sets, every result checked against a pinned or predicted value.
// Depends on sbf_pkg and stereo_biquad_filter.
`timescale 1ns / 1ps

module tb_stereo_biquad_filter;
    import sbf_pkg::*;

    localparam int     CYCLE_LIMIT      = 200000;
    localparam int     DRAIN_CYCLES     = 4;
    localparam int     HOLD_CYCLES      = 80;
    localparam int     IDLE_PERCENT     = 31;
    localparam int     PHASE_COUNT      = 8;
    localparam int     PHASE_SAMPLES    = 144;
    localparam longint OUT_MAX          = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint OUT_MIN          = -OUT_MAX - 1;
    localparam sample_t SAMPLE_MAX      = 16'sh7FFF;
    localparam sample_t SAMPLE_MIN      = 16'sh8000;
    localparam coef_t  COEF_MAX         = 20'sh7FFFF;
    localparam coef_t  COEF_MIN         = 20'sh80000;
    localparam coef_t  COEF_HALF        = 20'sd32768;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = 3'd7;

    typedef struct {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] cfg_idx;
        coef_t                cfg_val;
        sbf_in_t              item;
        logic                 pinned;
        sbf_out_t             want;
    } plan_row_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    sbf_in_t              sample_data  = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    sbf_out_t             result_data;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    coef_t                cfg_data     = '0;

    logic      pin_valid    = 1'b0;
    sbf_out_t  pin_result   = '0;
    logic      send_idle_en = 1'b1;
    logic      recv_idle_en = 1'b1;
    int        hold_token   = 0;
    int        hold_seen    = 0;
    int        hold_left    = 0;

    coef_set_t model_coefs;
    sample_t   in_hist  [CHANNELS][2];
    sample_t   out_hist [CHANNELS][2];
    int        next_chan;

    sbf_out_t  expected_results [$];
    plan_row_t plan_rows [$];

    int cycle_count    = 0;
    int mismatch_count = 0;
    int samples_sent   = 0;
    int results_seen   = 0;
    int clipped_seen   = 0;
    int stream_starts  = 0;
    int coef_writes    = 0;

    stereo_biquad_filter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void clear_histories();
        for (int c = 0; c < CHANNELS; c++)
        begin
            in_hist[c][0]  = '0;
            in_hist[c][1]  = '0;
            out_hist[c][0] = '0;
            out_hist[c][1] = '0;
        end
        next_chan = 0;
    endfunction

    function automatic sbf_out_t filter_predict(input sbf_in_t item);
        longint   acc;
        longint   y;
        int       ch;
        sbf_out_t res;
        if (item.start_of_stream)
        begin
            clear_histories();
        end
        ch  = next_chan;
        acc = longint'(model_coefs.x0) * longint'(item.sample_in)
            + longint'(model_coefs.x1) * longint'(in_hist[ch][0])
            + longint'(model_coefs.x2) * longint'(in_hist[ch][1])
            - longint'(model_coefs.y1) * longint'(out_hist[ch][0])
            - longint'(model_coefs.y2) * longint'(out_hist[ch][1]);
        y = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
        res.clipped = 1'b0;
        if (y > OUT_MAX)
        begin
            y           = OUT_MAX;
            res.clipped = 1'b1;
        end
        if (y < OUT_MIN)
        begin
            y           = OUT_MIN;
            res.clipped = 1'b1;
        end
        in_hist[ch][1]  = in_hist[ch][0];
        in_hist[ch][0]  = item.sample_in;
        out_hist[ch][1] = out_hist[ch][0];
        out_hist[ch][0] = sample_t'(y);
        next_chan       = (ch + 1 >= CHANNELS) ? 0 : ch + 1;
        res.sample_out  = sample_t'(y);
        res.channel_out = ch[0];
        return res;
    endfunction

    function automatic void add_sample(input sample_t s, input logic sos, input logic pinned,
                                       input sample_t want_s, input logic want_ch,
                                       input logic want_clip);
        plan_row_t row;
        row        = '{default: '0};
        row.item   = '{sample_in: s, start_of_stream: sos};
        row.pinned = pinned;
        row.want   = '{sample_out: want_s, channel_out: want_ch, clipped: want_clip};
        plan_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input coef_t val);
        plan_row_t row;
        row         = '{default: '0};
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        plan_rows.push_back(row);
    endfunction

    function automatic sbf_in_t random_sample();
        sbf_in_t item;
        int      pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            item.sample_in = sample_t'($urandom);
        end
        else if (pick < 85)
        begin
            item.sample_in = sample_t'(int'($urandom_range(0, 64)) - 32);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       item.sample_in = SAMPLE_MAX;
                1:       item.sample_in = SAMPLE_MIN;
                2:       item.sample_in = '0;
                default: item.sample_in = '1;
            endcase
        end
        item.start_of_stream = ($urandom_range(0, 99) < 3);
        return item;
    endfunction

    function automatic coef_t small_coef();
        return coef_t'(int'($urandom_range(0, 131072)) - 65536);
    endfunction

    function automatic coef_set_t phase_coefs(input int phase);
        coef_set_t c;
        case (phase)
            1: c = '{x0: 20'sd4424, x1: 20'sd8848, x2: 20'sd4424,
                     y1: -20'sd74914, y2: 20'sd27053};
            2: c = '{x0: COEF_MAX, x1: COEF_MAX, x2: COEF_MAX, y1: COEF_MAX, y2: COEF_MAX};
            3: c = '{x0: COEF_MIN, x1: COEF_MIN, x2: COEF_MIN, y1: COEF_MIN, y2: COEF_MIN};
            4: c = '0;
            5: c = '{x0: 20'sd52429, x1: -20'sd104858, x2: 20'sd52429,
                     y1: -20'sd74914, y2: 20'sd27053};
            6: c = '{x0: coef_t'($urandom), x1: coef_t'($urandom), x2: coef_t'($urandom),
                     y1: coef_t'($urandom), y2: coef_t'($urandom)};
            default: c = '{x0: small_coef(), x1: small_coef(), x2: small_coef(),
                           y1: small_coef(), y2: small_coef()};
        endcase
        return c;
    endfunction

    task automatic drain_results();
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input coef_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_COEF_X0: model_coefs.x0 = val;
            REG_COEF_X1: model_coefs.x1 = val;
            REG_COEF_X2: model_coefs.x2 = val;
            REG_COEF_Y1: model_coefs.y1 = val;
            REG_COEF_Y2: model_coefs.y2 = val;
            default:     ;
        endcase
        coef_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_coefs(input coef_set_t c);
        write_coef(REG_COEF_X0, c.x0);
        write_coef(REG_COEF_X1, c.x1);
        write_coef(REG_COEF_X2, c.x2);
        write_coef(REG_COEF_Y1, c.y1);
        write_coef(REG_COEF_Y2, c.y2);
        write_coef(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                   coef_t'($urandom));
    endtask

    // Each sample request is held until the block accepts it.
    task automatic offer_sample(input sbf_in_t item, input logic pinned, input sbf_out_t want);
        while (send_idle_en && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample_data  <= item;
        pin_valid    <= pinned;
        pin_result   <= want;
        @(posedge clk);
        while (sample_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen    <= hold_token;
            hold_left    <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= recv_idle_en && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        sbf_out_t predicted;
        sbf_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (result_data.clipped === 1'b1)
            begin
                clipped_seen++;
            end
            if (expected_results.size() == 0)
            begin
                if (mismatch_count < 10)
                begin
                    $display("Result %0d arrived with no sample pending: %s%0d ch %0b clip %0b",
                             results_seen, "sample ", result_data.sample_out,
                             result_data.channel_out, result_data.clipped);
                end
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_data.sample_out !== want.sample_out
                    || result_data.channel_out !== want.channel_out
                    || result_data.clipped !== want.clipped)
                begin
                    if (mismatch_count < 10)
                    begin
                        $display("Result %0d: expected sample %0d ch %0b clip %0b, %s%0d%s%0b%s%0b",
                                 results_seen, want.sample_out, want.channel_out,
                                 want.clipped, "got sample ", result_data.sample_out,
                                 " ch ", result_data.channel_out, " clip ",
                                 result_data.clipped);
                    end
                    mismatch_count++;
                end
            end
        end
        if (rst_n && sample_valid && !sample_stall)
        begin
            samples_sent++;
            if (sample_data.start_of_stream)
            begin
                stream_starts++;
            end
            predicted = filter_predict(sample_data);
            expected_results.push_back(pin_valid ? pin_result : predicted);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus
        model_coefs    = '0;
        model_coefs.x0 = COEF_X0_RESET;
        clear_histories();

        // Unity gain after reset: outputs equal inputs and channels alternate.
        add_sample(16'sd0, 1'b1, 1'b1, 16'sd0, 1'b0, 1'b0);
        add_sample(SAMPLE_MAX, 1'b0, 1'b1, SAMPLE_MAX, 1'b1, 1'b0);
        add_sample(SAMPLE_MIN, 1'b0, 1'b1, SAMPLE_MIN, 1'b0, 1'b0);
        add_sample(-16'sd1, 1'b0, 1'b1, -16'sd1, 1'b1, 1'b0);
        add_sample(16'sh5555, 1'b0, 1'b1, 16'sh5555, 1'b0, 1'b0);
        add_sample(16'shAAAA, 1'b0, 1'b1, 16'shAAAA, 1'b1, 1'b0);
        add_sample(16'sd7, 1'b0, 1'b1, 16'sd7, 1'b0, 1'b0);
        // A stream start on the right channel restarts at the left one.
        add_sample(16'sd123, 1'b1, 1'b1, 16'sd123, 1'b0, 1'b0);
        add_cfg(REG_UNUSED_FIRST, 20'sh12345);
        add_cfg(REG_UNUSED_LAST, COEF_MIN);
        add_sample(16'sd100, 1'b0, 1'b1, 16'sd100, 1'b1, 1'b0);
        add_cfg(REG_COEF_X0, COEF_MAX);
        add_sample(SAMPLE_MAX, 1'b1, 1'b1, SAMPLE_MAX, 1'b0, 1'b1);
        add_sample(SAMPLE_MIN, 1'b0, 1'b1, SAMPLE_MIN, 1'b1, 1'b1);
        add_cfg(REG_COEF_X0, COEF_MIN);
        add_sample(SAMPLE_MAX, 1'b1, 1'b1, SAMPLE_MIN, 1'b0, 1'b1);
        add_sample(SAMPLE_MIN, 1'b0, 1'b1, SAMPLE_MAX, 1'b1, 1'b1);
        // Half gain exposes rounding of ties toward plus infinity.
        add_cfg(REG_COEF_X0, COEF_HALF);
        add_sample(16'sd1, 1'b1, 1'b1, 16'sd1, 1'b0, 1'b0);
        add_sample(-16'sd1, 1'b0, 1'b1, 16'sd0, 1'b1, 1'b0);
        add_sample(16'sd3, 1'b0, 1'b1, 16'sd2, 1'b0, 1'b0);
        add_sample(-16'sd3, 1'b0, 1'b1, -16'sd1, 1'b1, 1'b0);
        add_cfg(REG_COEF_X0, 20'sd65536);
        add_cfg(REG_COEF_X1, 20'sd32768);
        add_cfg(REG_COEF_X2, -20'sd65536);
        add_cfg(REG_COEF_Y1, -20'sd32768);
        add_cfg(REG_COEF_Y2, 20'sd16384);
        add_sample(16'sd1000, 1'b1, 1'b0, '0, 1'b0, 1'b0);
        add_sample(-16'sd2000, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_sample(SAMPLE_MAX, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_sample(SAMPLE_MIN, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_sample(16'sd5, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_sample(-16'sd7, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_cfg(REG_COEF_Y1, COEF_MAX);
        add_cfg(REG_COEF_Y2, COEF_MIN);
        add_sample(16'sd30000, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_sample(-16'sd30000, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_sample(16'sd12345, 1'b0, 1'b0, '0, 1'b0, 1'b0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan_rows[i])
        begin
            if (plan_rows[i].is_cfg)
            begin
                sample_valid <= 1'b0;
                drain_results();
                write_coef(plan_rows[i].cfg_idx, plan_rows[i].cfg_val);
            end
            else
            begin
                offer_sample(plan_rows[i].item, plan_rows[i].pinned, plan_rows[i].want);
            end
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            sample_valid <= 1'b0;
            drain_results();
            load_coefs(phase_coefs(phase));
            send_idle_en  = !(phase == 2 || phase == 3);
            recv_idle_en <= !(phase == 2 || phase == 3);
            for (int k = 0; k < PHASE_SAMPLES; k++)
            begin
                sbf_in_t item;
                item = random_sample();
                if (k == 0)
                begin
                    item.start_of_stream = 1'b1;
                end
                // The result side holds off while samples keep coming, so the block backs up.
                if (phase == 2 && k == 40)
                begin
                    hold_token <= hold_token + 1;
                end
                offer_sample(item, 1'b0, '0);
            end
        end

        sample_valid <= 1'b0;
        drain_results();
        $display("Sent %0d samples (%0d stream starts) over %0d coefficient writes;",
                 samples_sent, stream_starts, coef_writes);
        $display("checked %0d results, %0d of them saturated, %0d mismatching.",
                 results_seen, clipped_seen, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/sbf_pkg.sv
hw/rtl/sbf_coef_regs.sv
hw/rtl/sbf_datapath.sv
hw/rtl/stereo_biquad_filter.sv
tb/tb_stereo_biquad_filter.sv
